@@ hw/rtl/rtp_reorder_window_buffer_unit_assert.svh @@
// Assertion macros for the RTP reorder window buffer.
// Used by the top level; depends on nothing else.
`ifndef RTP_REORDER_WINDOW_BUFFER_UNIT_ASSERT_SVH
`define RTP_REORDER_WINDOW_BUFFER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define RRWB_ASSERT_IMPLIES(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("rrwb: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define RRWB_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("rrwb: next-cycle check failed");

`endif

@@ hw/rtl/rrwb_pkg.sv @@
// Shared types and constants of the RTP reorder window buffer.
// Used by every RTL source file of the block but the assert header; depends on nothing.
`default_nettype none

package rrwb_pkg;

    // Window geometry (DEPTH is a power of two, the slots form a ring)
    localparam int DEPTH      = 32;
    localparam int MAX_OUT    = 32;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int RUN_W      = $clog2(DEPTH + 1);
    localparam int WANT_MAX   = (DEPTH < MAX_OUT) ? DEPTH : MAX_OUT;

    // Field widths
    localparam int CMD_W      = 2;
    localparam int SSRC_W     = 32;
    localparam int SEQ_W      = 16;
    localparam int TAG_W      = 16;
    localparam int WANT_W     = 6;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 6;
    localparam int LIMIT_W    = 8;
    localparam int MISS_W     = LIMIT_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd5;

    // Front-to-back queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT  = 2'd0,
        CMD_GET  = 2'd1,
        CMD_LOOK = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK  = 2'd0,
        ST_DUP = 2'd1,
        ST_OOW = 2'd2,
        ST_REJ = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOWEST     = 2'd0,
        REG_HIGHEST    = 2'd1,
        REG_BLOCKED    = 2'd2,
        REG_MISS_LIMIT = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_PUT,
        BS_GET,
        BS_LOOK
    } back_state_t;

    // Classified item as queued between front and back
    typedef struct packed {
        cmd_t              cmd;
        logic              rejected;
        logic [SEQ_W-1:0]  seq;
        logic [TAG_W-1:0]  tag;
        logic [WANT_W-1:0] want;
    } entry_t;

    // Configuration effects seen by the back end
    typedef struct packed {
        logic               clear;
        logic [LIMIT_W-1:0] miss_limit;
    } cfg_ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/rrwb_if.sv @@
// Channel interfaces of the RTP reorder window buffer: items, results, config.
// Depends on rrwb_pkg.
`default_nettype none

interface rrwb_item_if;
    logic                         valid;
    logic                         ready;
    logic [rrwb_pkg::CMD_W-1:0]   cmd;
    logic [rrwb_pkg::SSRC_W-1:0]  ssrc;
    logic [rrwb_pkg::SEQ_W-1:0]   seq;
    logic [rrwb_pkg::TAG_W-1:0]   frame_tag;
    logic [rrwb_pkg::WANT_W-1:0]  want_count;

    modport source (output valid, cmd, ssrc, seq, frame_tag, want_count, input ready);
    modport sink   (input valid, cmd, ssrc, seq, frame_tag, want_count, output ready);
endinterface

interface rrwb_result_if;
    logic                          valid;
    logic                          ready;
    logic [rrwb_pkg::STATUS_W-1:0] status;
    logic                          has_frame;
    logic [rrwb_pkg::TAG_W-1:0]    out_tag;
    logic [rrwb_pkg::SEQ_W-1:0]    out_seq;
    logic [rrwb_pkg::COUNT_W-1:0]  ready_count;
    logic                          last;

    modport source (output valid, status, has_frame, out_tag, out_seq, ready_count, last,
                    input ready);
    modport sink   (input valid, status, has_frame, out_tag, out_seq, ready_count, last,
                    output ready);
endinterface

interface rrwb_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [rrwb_pkg::CFG_IDX_W-1:0]  index;
    logic [rrwb_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/rrwb_front.sv @@
// Front end: configuration registers, item intake and source classification.
// Depends on rrwb_pkg and rrwb_if.
`default_nettype none

module rrwb_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    rrwb_item_if.sink         req,
    rrwb_cfg_if.sink          cfg,
    output rrwb_pkg::entry_t  push_entry,
    output logic              push_valid,
    input  wire logic         push_ready,
    output rrwb_pkg::cfg_ctrl_t cfg_ctrl
);

    logic [rrwb_pkg::SSRC_W-1:0]  lowest_reg;
    logic [rrwb_pkg::SSRC_W-1:0]  highest_reg;
    logic [rrwb_pkg::SSRC_W-1:0]  blocked_reg;
    logic [rrwb_pkg::LIMIT_W-1:0] limit_reg;
    logic                         cfg_we;
    logic                         known_cmd;

    // Config port never stalls
    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid && cfg.ready;

    // Config register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lowest_reg  <= '0;
            highest_reg <= '0;
            blocked_reg <= '0;
            limit_reg   <= rrwb_pkg::LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg.index)
                rrwb_pkg::REG_LOWEST:     lowest_reg  <= cfg.data;
                rrwb_pkg::REG_HIGHEST:    highest_reg <= cfg.data;
                rrwb_pkg::REG_BLOCKED:    blocked_reg <= cfg.data;
                rrwb_pkg::REG_MISS_LIMIT: limit_reg   <= cfg.data[rrwb_pkg::LIMIT_W-1:0];
                default:                  ;
            endcase
        end
    end

    // A write to either range bound restarts the stream
    assign cfg_ctrl.clear      = cfg_we && (cfg.index == rrwb_pkg::REG_LOWEST ||
                                            cfg.index == rrwb_pkg::REG_HIGHEST);
    assign cfg_ctrl.miss_limit = limit_reg;

    // Intake: unused command code is taken and dropped
    assign known_cmd  = (req.cmd == rrwb_pkg::CMD_PUT) || (req.cmd == rrwb_pkg::CMD_GET) ||
                        (req.cmd == rrwb_pkg::CMD_LOOK);
    assign req.ready  = push_ready;
    assign push_valid = req.valid && known_cmd;

    // Classification
    always_comb
    begin
        push_entry.cmd      = rrwb_pkg::cmd_t'(req.cmd);
        push_entry.rejected = (req.ssrc == blocked_reg) || (req.ssrc < lowest_reg) ||
                              (req.ssrc > highest_reg);
        push_entry.seq      = req.seq;
        push_entry.tag      = req.frame_tag;
        if (req.want_count > rrwb_pkg::WANT_W'(rrwb_pkg::WANT_MAX))
            push_entry.want = rrwb_pkg::WANT_W'(rrwb_pkg::WANT_MAX);
        else
            push_entry.want = req.want_count;
    end

endmodule

`default_nettype wire

@@ hw/rtl/rrwb_queue.sv @@
// Short FIFO of classified items between front and back end.
// Depends on rrwb_pkg.
`default_nettype none

module rrwb_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_valid,
    output logic                   push_ready,
    input  wire rrwb_pkg::entry_t  push_entry,
    output logic                   pop_valid,
    input  wire logic              pop_ready,
    output rrwb_pkg::entry_t       pop_entry
);

    rrwb_pkg::entry_t              store_reg [rrwb_pkg::QUEUE_DEPTH];
    logic [rrwb_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [rrwb_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [rrwb_pkg::QPTR_W:0]     count_reg;
    logic                          do_push;
    logic                          do_pop;

    assign push_ready = (count_reg != (rrwb_pkg::QPTR_W + 1)'(rrwb_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = store_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + rrwb_pkg::QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + rrwb_pkg::QPTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + (rrwb_pkg::QPTR_W + 1)'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - (rrwb_pkg::QPTR_W + 1)'(1);
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            store_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

`default_nettype wire

@@ hw/rtl/rrwb_back.sv @@
// Back end: window state, slot ring and result sequencer with output register.
// Depends on rrwb_pkg and rrwb_if.
`default_nettype none

module rrwb_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 pop_valid,
    output logic                      pop_ready,
    input  wire rrwb_pkg::entry_t     pop_entry,
    input  wire rrwb_pkg::cfg_ctrl_t  cfg_ctrl,
    rrwb_result_if.source             rsp
);

    // Window state
    logic [rrwb_pkg::DEPTH-1:0]   filled_reg,  filled_next;
    logic [rrwb_pkg::TAG_W-1:0]   tag_reg [rrwb_pkg::DEPTH];
    logic [rrwb_pkg::SEQ_W-1:0]   ws_reg,      ws_next;
    logic [rrwb_pkg::PTR_W-1:0]   head_reg,    head_next;
    logic                         started_reg, started_next;
    logic [rrwb_pkg::MISS_W-1:0]  miss_reg,    miss_next;

    // Sequencer
    rrwb_pkg::back_state_t        state_reg,   state_next;
    rrwb_pkg::entry_t             cur_reg,     cur_next;
    logic [rrwb_pkg::WANT_W-1:0]  remain_reg,  remain_next;
    logic [rrwb_pkg::RUN_W-1:0]   scan_reg,    scan_next;

    // Output register
    logic                         out_valid_reg, out_valid_next;
    rrwb_pkg::status_t            status_reg;
    logic                         has_reg;
    logic [rrwb_pkg::TAG_W-1:0]   otag_reg;
    logic [rrwb_pkg::SEQ_W-1:0]   oseq_reg;
    logic [rrwb_pkg::COUNT_W-1:0] count_reg;
    logic                         last_reg;

    logic                         out_free;
    logic                         out_load;
    rrwb_pkg::status_t            o_status;
    logic                         o_has;
    logic [rrwb_pkg::TAG_W-1:0]   o_tag;
    logic [rrwb_pkg::SEQ_W-1:0]   o_seq;
    logic [rrwb_pkg::COUNT_W-1:0] o_count;
    logic                         o_last;

    logic                         tag_we;
    logic [rrwb_pkg::PTR_W-1:0]   tag_waddr;

    logic [rrwb_pkg::SEQ_W-1:0]   put_off;
    logic [rrwb_pkg::PTR_W-1:0]   put_slot;
    logic [rrwb_pkg::PTR_W-1:0]   head_inc;
    logic [rrwb_pkg::PTR_W-1:0]   look_slot;
    logic [rrwb_pkg::MISS_W-1:0]  miss_inc;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign put_off   = cur_reg.seq - ws_reg;
    assign put_slot  = head_reg + put_off[rrwb_pkg::PTR_W-1:0];
    assign head_inc  = head_reg + rrwb_pkg::PTR_W'(1);
    assign look_slot = head_reg + scan_reg[rrwb_pkg::PTR_W-1:0];
    assign miss_inc  = miss_reg + rrwb_pkg::MISS_W'(1);

    // Next state and result generation
    always_comb
    begin
        filled_next  = filled_reg;
        ws_next      = ws_reg;
        head_next    = head_reg;
        started_next = started_reg;
        miss_next    = miss_reg;
        state_next   = state_reg;
        cur_next     = cur_reg;
        remain_next  = remain_reg;
        scan_next    = scan_reg;
        pop_ready    = 1'b0;
        tag_we       = 1'b0;
        tag_waddr    = head_reg;
        out_load     = 1'b0;
        o_status     = rrwb_pkg::ST_OK;
        o_has        = 1'b0;
        o_tag        = '0;
        o_seq        = '0;
        o_count      = '0;
        o_last       = 1'b1;

        unique case (state_reg)
            rrwb_pkg::BS_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    cur_next    = pop_entry;
                    remain_next = pop_entry.want;
                    scan_next   = '0;
                    unique case (pop_entry.cmd)
                        rrwb_pkg::CMD_PUT:  state_next = rrwb_pkg::BS_PUT;
                        rrwb_pkg::CMD_GET:  state_next = rrwb_pkg::BS_GET;
                        rrwb_pkg::CMD_LOOK: state_next = rrwb_pkg::BS_LOOK;
                        default:            state_next = rrwb_pkg::BS_IDLE;
                    endcase
                end
            end

            // One result; at most one slot written, or the window cleared after too many misses
            rrwb_pkg::BS_PUT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = rrwb_pkg::BS_IDLE;
                    if (cur_reg.rejected)
                        o_status = rrwb_pkg::ST_REJ;
                    else if (!started_reg)
                    begin
                        started_next         = 1'b1;
                        ws_next              = cur_reg.seq;
                        filled_next[head_reg] = 1'b1;
                        tag_we               = 1'b1;
                        tag_waddr            = head_reg;
                    end
                    else if (put_off >= rrwb_pkg::SEQ_W'(rrwb_pkg::DEPTH))
                    begin
                        o_status = rrwb_pkg::ST_OOW;
                        if (miss_inc > {1'b0, cfg_ctrl.miss_limit})
                        begin
                            filled_next  = '0;
                            ws_next      = cur_reg.seq;
                            head_next    = '0;
                            miss_next    = '0;
                            started_next = 1'b0;
                        end
                        else
                            miss_next = miss_inc;
                    end
                    else if (filled_reg[put_slot])
                        o_status = rrwb_pkg::ST_DUP;
                    else
                    begin
                        filled_next[put_slot] = 1'b1;
                        tag_we                = 1'b1;
                        tag_waddr             = put_slot;
                        miss_next             = '0;
                    end
                end
            end

            // One frame per cycle from the head while the output is free, window slides as it goes
            rrwb_pkg::BS_GET:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (remain_reg == '0 || !filled_reg[head_reg])
                        state_next = rrwb_pkg::BS_IDLE;
                    else
                    begin
                        o_has                 = 1'b1;
                        o_tag                 = tag_reg[head_reg];
                        o_seq                 = ws_reg;
                        o_last                = (remain_reg == rrwb_pkg::WANT_W'(1)) ||
                                                !filled_reg[head_inc];
                        filled_next[head_reg] = 1'b0;
                        head_next             = head_inc;
                        ws_next               = ws_reg + rrwb_pkg::SEQ_W'(1);
                        remain_next           = remain_reg - rrwb_pkg::WANT_W'(1);
                        if (o_last)
                            state_next = rrwb_pkg::BS_IDLE;
                    end
                end
            end

            // Walk the run one slot per cycle, then report
            rrwb_pkg::BS_LOOK:
            begin
                if (scan_reg < rrwb_pkg::RUN_W'(rrwb_pkg::DEPTH) && filled_reg[look_slot])
                    scan_next = scan_reg + rrwb_pkg::RUN_W'(1);
                else if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = rrwb_pkg::BS_IDLE;
                    if (scan_reg != '0)
                    begin
                        o_has   = 1'b1;
                        o_seq   = ws_reg;
                        o_count = rrwb_pkg::COUNT_W'(scan_reg);
                    end
                end
            end

            default:
                state_next = rrwb_pkg::BS_IDLE;
        endcase

        // Range register write empties the window
        if (cfg_ctrl.clear)
        begin
            filled_next  = '0;
            ws_next      = '0;
            head_next    = '0;
            miss_next    = '0;
            started_next = 1'b0;
        end

        out_valid_next = out_load || (out_valid_reg && !rsp.ready);
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg    <= '0;
            ws_reg        <= '0;
            head_reg      <= '0;
            started_reg   <= 1'b0;
            miss_reg      <= '0;
            state_reg     <= rrwb_pkg::BS_IDLE;
            remain_reg    <= '0;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            filled_reg    <= filled_next;
            ws_reg        <= ws_next;
            head_reg      <= head_next;
            started_reg   <= started_next;
            miss_reg      <= miss_next;
            state_reg     <= state_next;
            remain_reg    <= remain_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: current item, slot tags, output register
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (tag_we)
            tag_reg[tag_waddr] <= cur_reg.tag;
        if (out_load)
        begin
            status_reg <= o_status;
            has_reg    <= o_has;
            otag_reg   <= o_tag;
            oseq_reg   <= o_seq;
            count_reg  <= o_count;
            last_reg   <= o_last;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.has_frame   = has_reg;
    assign rsp.out_tag     = otag_reg;
    assign rsp.out_seq     = oseq_reg;
    assign rsp.ready_count = count_reg;
    assign rsp.last        = last_reg;

endmodule

`default_nettype wire

@@ hw/rtl/rtp_reorder_window_buffer_unit.sv @@
// Top level of the RTP reorder window buffer: front end, queue, back end.
// Depends on rrwb_pkg, rrwb_if, rrwb_front, rrwb_queue, rrwb_back and the assert header.
//
// Usage:
//   req  - items: put (store a frame tag by sequence number), get (take up to
//          want_count frames of the contiguous run from the head), lookahead.
//   rsp  - results; put and lookahead give one, get gives one per frame (or one
//          empty result), last marks the final result of an item.
//   cfg  - register writes, always ready; write only while the block is idle.
//          Writing a range bound empties the window.
// Path: the first result of a put or get passes the queue, the back end's item register
// and the output register when nothing waits; a lookahead first walks its run.
// Order: the back end works on one item at a time and takes a new one only from idle;
// a get gives its frames back to back while the output is free, and a lookahead walks
// the run one slot per cycle before it reports.
// A two-entry queue lets the front take items while the back works.
// Reset: all slots empty, window at 0, limit 5; no clearing pass is needed.
// Receiver stall: the output register holds its result and the back end
// waits; the queue keeps accepting until it is full.
`default_nettype none
`include "rtp_reorder_window_buffer_unit_assert.svh"

module rtp_reorder_window_buffer_unit (
    input  wire logic   clk,
    input  wire logic   rst_n,
    rrwb_item_if.sink   req,
    rrwb_result_if.source rsp,
    rrwb_cfg_if.sink    cfg
);

    rrwb_pkg::entry_t    push_entry;
    logic                push_valid;
    logic                push_ready;
    rrwb_pkg::entry_t    pop_entry;
    logic                pop_valid;
    logic                pop_ready;
    rrwb_pkg::cfg_ctrl_t cfg_ctrl;

    rrwb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .cfg        (cfg),
        .push_entry (push_entry),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .cfg_ctrl   (cfg_ctrl)
    );

    rrwb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    rrwb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry),
        .cfg_ctrl   (cfg_ctrl),
        .rsp        (rsp)
    );

    // A result without a frame carries nothing else and ends its item
    `RRWB_ASSERT_IMPLIES(a_empty_result_clean, clk, rst_n, rsp.valid && !rsp.has_frame, rsp.out_tag == '0 && rsp.out_seq == '0 && rsp.ready_count == '0 && rsp.last)

    // Only a lookahead reports a run, always as a single ok result
    `RRWB_ASSERT_IMPLIES(a_run_only_on_look, clk, rst_n, rsp.valid && rsp.ready_count != '0, rsp.has_frame && rsp.last && rsp.status == rrwb_pkg::ST_OK)

    // A get run is never interrupted by a gap cycle
    `RRWB_ASSERT_NEXT(a_get_run_gapless, clk, rst_n, rsp.valid && !rsp.last, rsp.valid)

endmodule

`default_nettype wire

@@ tb/rtp_reorder_window_buffer_unit_tb.sv @@
// Testbench for the RTP reorder window buffer: directed and random puts, gets
// and lookaheads checked against a window tracker. Depends on rrwb_pkg, rrwb_if
// and the rtp_reorder_window_buffer_unit RTL.
import rrwb_pkg::*;

typedef struct {
    status_t            status;
    logic               has_frame;
    logic [TAG_W-1:0]   out_tag;
    logic [SEQ_W-1:0]   out_seq;
    logic [COUNT_W-1:0] ready_count;
    logic               last;
} frame_result_t;

// Tracks the window contents and registers; predicts and checks results
class reorder_window_tracker;
    logic [SSRC_W-1:0]  lowest_ssrc;
    logic [SSRC_W-1:0]  highest_ssrc;
    logic [SSRC_W-1:0]  blocked_ssrc;
    logic [LIMIT_W-1:0] miss_limit;

    bit                 filled [DEPTH];
    logic [TAG_W-1:0]   tags [DEPTH];
    logic [SEQ_W-1:0]   window_start;
    int                 head;
    bit                 started;
    int                 misses;

    frame_result_t      due_results[$];
    int                 mismatches;

    function new();
        lowest_ssrc  = '0;
        highest_ssrc = '0;
        blocked_ssrc = '0;
        miss_limit   = LIMIT_RESET;
        mismatches   = 0;
        clear_window('0);
    endfunction

    function void clear_window(logic [SEQ_W-1:0] start);
        for (int i = 0; i < DEPTH; i++)
        begin
            filled[i] = 1'b0;
            tags[i]   = '0;
        end
        window_start = start;
        head         = 0;
        misses       = 0;
        started      = 1'b0;
    endfunction

    function int slot(int off);
        return (head + off) % DEPTH;
    endfunction

    // Register write; a range bound also empties the window
    function void apply_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
        case (idx)
            REG_LOWEST:
            begin
                lowest_ssrc = d;
                clear_window('0);
            end
            REG_HIGHEST:
            begin
                highest_ssrc = d;
                clear_window('0);
            end
            REG_BLOCKED:    blocked_ssrc = d;
            REG_MISS_LIMIT: miss_limit = d[LIMIT_W-1:0];
            default: ;
        endcase
    endfunction

    function void queue_result(status_t st, logic h, logic [TAG_W-1:0] t,
                               logic [SEQ_W-1:0] q, int run, logic l);
        frame_result_t r;
        r.status      = st;
        r.has_frame   = h;
        r.out_tag     = t;
        r.out_seq     = q;
        r.ready_count = COUNT_W'(run);
        r.last        = l;
        due_results.push_back(r);
    endfunction

    // Slot update of a put, returns its status
    function status_t put_status(logic [SSRC_W-1:0] s, logic [SEQ_W-1:0] q,
                                 logic [TAG_W-1:0] t);
        logic [SEQ_W-1:0] delta;
        int               off;
        if (s == blocked_ssrc || s < lowest_ssrc || s > highest_ssrc)
            return ST_REJ;
        // first accepted put opens the window at its own number
        if (!started)
        begin
            started      = 1'b1;
            window_start = q;
            filled[head] = 1'b1;
            tags[head]   = t;
            return ST_OK;
        end
        delta = q - window_start;
        off   = int'(delta);
        if (off >= DEPTH)
        begin
            misses++;
            if (misses > int'(miss_limit))
                clear_window(q);
            return ST_OOW;
        end
        if (filled[slot(off)])
            return ST_DUP;
        filled[slot(off)] = 1'b1;
        tags[slot(off)]   = t;
        misses            = 0;
        return ST_OK;
    endfunction

    // Accepted item: work out the results it must cause
    function void note_item(logic [CMD_W-1:0] c, logic [SSRC_W-1:0] s,
                            logic [SEQ_W-1:0] q, logic [TAG_W-1:0] t,
                            logic [WANT_W-1:0] w);
        int               n;
        int               lim;
        int               p;
        logic [SEQ_W-1:0] fseq;
        case (c)
            CMD_PUT: queue_result(put_status(s, q, t), 1'b0, '0, '0, 0, 1'b1);
            CMD_GET:
            begin
                lim = (int'(w) > WANT_MAX) ? WANT_MAX : int'(w);
                n   = 0;
                while (n < lim && filled[slot(n)])
                    n++;
                if (n == 0)
                    queue_result(ST_OK, 1'b0, '0, '0, 0, 1'b1);
                for (int i = 0; i < n; i++)
                begin
                    p    = slot(i);
                    fseq = window_start + SEQ_W'(i);
                    queue_result(ST_OK, 1'b1, tags[p], fseq, 0, i == n - 1);
                    filled[p] = 1'b0;
                end
                head         = slot(n);
                window_start = window_start + SEQ_W'(n);
            end
            CMD_LOOK:
            begin
                if (filled[slot(0)])
                begin
                    n = 0;
                    while (n < DEPTH && filled[slot(n)])
                        n++;
                    if (n > (1 << COUNT_W) - 1)
                        n = (1 << COUNT_W) - 1;
                    queue_result(ST_OK, 1'b1, '0, window_start, n, 1'b1);
                end
                else
                    queue_result(ST_OK, 1'b0, '0, '0, 0, 1'b1);
            end
            default: ; // unused code: nothing comes out
        endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $error("%s: expected %0h, actual %0h", name, want, got);
        end
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic h, logic [TAG_W-1:0] t,
                               logic [SEQ_W-1:0] q, logic [COUNT_W-1:0] run, logic l);
        frame_result_t e;
        if (due_results.size() == 0)
        begin
            mismatches++;
            $error("result with no item outstanding: status %0h out_seq %0h", st, q);
            return;
        end
        e = due_results.pop_front();
        compare_field("status", 32'(e.status), 32'(st));
        compare_field("has_frame", 32'(e.has_frame), 32'(h));
        compare_field("out_tag", 32'(e.out_tag), 32'(t));
        compare_field("out_seq", 32'(e.out_seq), 32'(q));
        compare_field("ready_count", 32'(e.ready_count), 32'(run));
        compare_field("last", 32'(e.last), 32'(l));
    endfunction
endclass

module rtp_reorder_window_buffer_unit_tb;
    // command code the block ignores
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    // covers a lookahead walking a full window
    localparam int SETTLE_CYCLES = 50;

    logic clk;
    logic rst_n;

    rrwb_item_if   req ();
    rrwb_result_if rsp ();
    rrwb_cfg_if    cfg ();

    reorder_window_tracker tracker;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int items_sent    = 0;

    rtp_reorder_window_buffer_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Receiver stalls
    always @(posedge clk)
        rsp.ready <= ($urandom_range(99) >= stall_pct);

    // Watch all three channels; results are checked before new items are noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
                tracker.check_result(rsp.status, rsp.has_frame, rsp.out_tag, rsp.out_seq,
                                     rsp.ready_count, rsp.last);
            if (req.valid && req.ready)
                tracker.note_item(req.cmd, req.ssrc, req.seq, req.frame_tag,
                                  req.want_count);
            if (cfg.valid && cfg.ready)
                tracker.apply_reg(cfg_reg_t'(cfg.index), cfg.data);
        end
    end

    // Random field values of the item widths
    function automatic logic [SEQ_W-1:0] any_seq();
        return SEQ_W'($urandom);
    endfunction

    function automatic logic [TAG_W-1:0] any_tag();
        return TAG_W'($urandom);
    endfunction

    function automatic logic [WANT_W-1:0] any_want();
        return WANT_W'($urandom);
    endfunction

    // Present one item, wait for it to be taken, then maybe go idle
    task automatic send_item(input logic [CMD_W-1:0] c, input logic [SSRC_W-1:0] s,
                             input logic [SEQ_W-1:0] q, input logic [TAG_W-1:0] t,
                             input logic [WANT_W-1:0] w);
        req.valid      <= 1'b1;
        req.cmd        <= c;
        req.ssrc       <= s;
        req.seq        <= q;
        req.frame_tag  <= t;
        req.want_count <= w;
        do @(posedge clk); while (!req.ready);
        if (c != CMD_UNUSED)
            items_sent++;
        if ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic hold_items();
        req.valid <= 1'b0;
    endtask

    task automatic wait_for_results();
        do @(posedge clk); while (tracker.due_results.size() != 0);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] d);
        @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= d;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
    endtask

    // Registers change only with the block drained and settled
    task automatic configure(input logic [SSRC_W-1:0] lo, input logic [SSRC_W-1:0] hi,
                             input logic [SSRC_W-1:0] blk, input logic [LIMIT_W-1:0] lim);
        hold_items();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(REG_LOWEST, lo);
        write_reg(REG_HIGHEST, hi);
        write_reg(REG_BLOCKED, blk);
        write_reg(REG_MISS_LIMIT, 32'(lim));
    endtask

    // Source identifier that passes the range and blocked checks
    function automatic logic [SSRC_W-1:0] good_ssrc();
        logic [63:0]       span;
        logic [63:0]       pick;
        logic [SSRC_W-1:0] v;
        span = {32'd0, tracker.highest_ssrc} - {32'd0, tracker.lowest_ssrc} + 64'd1;
        v    = tracker.lowest_ssrc;
        for (int k = 0; k < 8; k++)
        begin
            case ($urandom_range(7))
                0: v = tracker.lowest_ssrc;
                1: v = tracker.highest_ssrc;
                default:
                begin
                    pick = {$urandom, $urandom} % span;
                    v    = tracker.lowest_ssrc + pick[31:0];
                end
            endcase
            if (v != tracker.blocked_ssrc)
                break;
        end
        return v;
    endfunction

    // n consecutive frames, the first at the base and the rest shuffled, then lookahead and get them all
    task automatic fill_run(input int n);
        int               order[$];
        int               j;
        int               k;
        int               tmp;
        logic [SEQ_W-1:0] base;
        logic [SEQ_W-1:0] q;
        base = tracker.started ? tracker.window_start : any_seq();
        for (k = 1; k < n; k++)
            order.push_back(k);
        for (k = order.size() - 1; k > 0; k--)
        begin
            j        = int'($urandom_range(k));
            tmp      = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        send_item(CMD_PUT, good_ssrc(), base, any_tag(), any_want());
        foreach (order[i])
        begin
            q = base + SEQ_W'(order[i]);
            send_item(CMD_PUT, good_ssrc(), q, any_tag(), any_want());
        end
        send_item(CMD_LOOK, $urandom, any_seq(), any_tag(), any_want());
        send_item(CMD_GET, $urandom, any_seq(), any_tag(), WANT_W'(n));
    endtask

    // Mostly puts near the window with gets and lookaheads, plus noise
    task automatic random_item();
        int                pick;
        logic [SEQ_W-1:0]  q;
        logic [WANT_W-1:0] w;
        pick = int'($urandom_range(99));
        q    = tracker.window_start + SEQ_W'($urandom_range(0, 40));
        w    = ($urandom_range(3) == 0) ? WANT_W'($urandom_range(0, 63))
                                        : WANT_W'($urandom_range(1, 33));
        if (pick < 5)
            send_item(CMD_PUT, good_ssrc(), any_seq(), any_tag(), any_want());
        else if (pick < 55)
            send_item(CMD_PUT, good_ssrc(), q, any_tag(), any_want());
        else if (pick < 72)
            send_item(CMD_GET, $urandom, any_seq(), any_tag(), w);
        else if (pick < 85)
            send_item(CMD_LOOK, $urandom, any_seq(), any_tag(), any_want());
        else if (pick < 95)
            send_item(CMD_PUT, $urandom, any_seq(), any_tag(), any_want());
        else
            send_item(CMD_UNUSED, $urandom, any_seq(), any_tag(), any_want());
    endtask

    task automatic run_items(input int n);
        int target;
        target = items_sent + n;
        while (items_sent < target)
            random_item();
    endtask

    initial
    begin
        tracker        = new();
        rst_n          = 1'b0;
        req.valid      = 1'b0;
        req.cmd        = CMD_PUT;
        req.ssrc       = '0;
        req.seq        = '0;
        req.frame_tag  = '0;
        req.want_count = '0;
        rsp.ready      = 1'b0;
        cfg.valid      = 1'b0;
        cfg.index      = REG_LOWEST;
        cfg.data       = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: the only in-range source is also the blocked one
        send_item(CMD_PUT, 32'd0, 16'd10, 16'h1234, 6'd0);
        send_item(CMD_LOOK, 32'd0, 16'd0, 16'd0, 6'd0);
        send_item(CMD_GET, 32'd0, 16'd0, 16'd0, 6'd5);

        // Directed: range 100..200, 150 blocked, two misses tolerated
        configure(32'd100, 32'd200, 32'd150, 8'd2);
        send_item(CMD_LOOK, 32'd0, 16'd0, 16'd0, 6'd0);        // empty head
        send_item(CMD_GET, 32'd0, 16'd0, 16'd0, 6'd0);         // nothing ready
        send_item(CMD_PUT, 32'd99, 16'd7, 16'd1, 6'd0);        // below range
        send_item(CMD_PUT, 32'd201, 16'd7, 16'd1, 6'd0);       // above range
        send_item(CMD_PUT, 32'd150, 16'd7, 16'd1, 6'd0);       // blocked source
        send_item(CMD_PUT, 32'd100, 16'hFFFE, 16'hFFFF, 6'd0); // opens the window
        send_item(CMD_PUT, 32'd200, 16'hFFFF, 16'd1, 6'd0);
        send_item(CMD_PUT, 32'd120, 16'd0, 16'd0, 6'd0);       // sequence wraps
        send_item(CMD_PUT, 32'd120, 16'hFFFE, 16'd2, 6'd0);    // duplicate
        send_item(CMD_PUT, 32'd120, 16'd29, 16'd3, 6'd0);      // last window slot
        send_item(CMD_PUT, 32'd120, 16'd30, 16'd4, 6'd0);      // just past the window
        send_item(CMD_LOOK, 32'd0, 16'd0, 16'd0, 6'd0);
        send_item(CMD_GET, 32'd0, 16'd0, 16'd0, 6'd63);        // count beyond depth
        send_item(CMD_GET, 32'd0, 16'd0, 16'd0, 6'd1);         // head now empty
        send_item(CMD_PUT, 32'd130, 16'd1, 16'hA5A5, 6'd0);    // clears the miss count
        send_item(CMD_GET, 32'd0, 16'd0, 16'd0, 6'd0);         // zero count
        send_item(CMD_PUT, 32'd130, 16'd1000, 16'd5, 6'd0);    // misses up to the limit
        send_item(CMD_PUT, 32'd130, 16'd1001, 16'd6, 6'd0);
        send_item(CMD_PUT, 32'd130, 16'd1002, 16'd7, 6'd0);    // restarts the stream
        send_item(CMD_LOOK, 32'd0, 16'd0, 16'd0, 6'd0);
        send_item(CMD_PUT, 32'd140, 16'd5000, 16'h5A5A, 6'd0);
        send_item(CMD_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 6'h3F);
        send_item(CMD_LOOK, 32'd0, 16'd0, 16'd0, 6'd0);
        fill_run(DEPTH);
        run_items(4);

        // Widest range, top value blocked, no misses tolerated; sender idles
        configure(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0);
        send_idle_pct = 80;
        fill_run(int'($urandom_range(4, 8)));
        run_items(3);
        hold_items();
        wait_for_results();
        run_items(3);

        // Upper half of the range, maximum miss limit; receiver stalls
        configure(32'h8000_0000, 32'hFFFF_FFFE, 32'h8000_0001, 8'd255);
        send_idle_pct = 0;
        stall_pct     = 80;
        fill_run(int'($urandom_range(4, 8)));
        run_items(4);

        // Low range, reset miss limit; light pressure on both sides
        configure(32'd0, 32'h0000_FFFF, 32'd0, LIMIT_RESET);
        send_idle_pct = 15;
        stall_pct     = 15;
        fill_run(int'($urandom_range(4, 8)));
        run_items(4);

        hold_items();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.due_results.size() == 0)
            $display("PASS rtp_reorder_window_buffer_unit");
        else
            $display("FAIL rtp_reorder_window_buffer_unit");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_400_000;
        $display("FAIL rtp_reorder_window_buffer_unit");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/rrwb_pkg.sv
hw/rtl/rrwb_if.sv
hw/rtl/rrwb_front.sv
hw/rtl/rrwb_queue.sv
hw/rtl/rrwb_back.sv
hw/rtl/rtp_reorder_window_buffer_unit.sv
tb/rtp_reorder_window_buffer_unit_tb.sv
